/* rtl/core/hvd_pkg.sv */
`timescale 1ns / 1ps
package hvd_pkg;

  // Input field limits in microdegrees.
  localparam logic signed [27:0] LAT_MAX = 28'sd90000000;
  localparam logic signed [28:0] LON_MAX = 29'sd180000000;
  localparam logic signed [29:0] TURN_UDEG = 30'sd360000000;

  // pi * 2^34.
  localparam logic [35:0] PIQ34 = 36'd53972150818;

  // Divisors from scaled microdegrees to Q2.30 radians (full and half angle).
  localparam logic [32:0] DIV_FULL = 33'd2880000000;
  localparam logic [32:0] DIV_HALF = 33'd5760000000;

  // Widths of the datapath.
  localparam int unsigned ANG_W = 34;
  localparam int unsigned QUO_W = 31;
  localparam int unsigned REM_W = 33;
  localparam int unsigned SQ_W = 61;

  // Angle conversion as QP * u + (RP * u + DIV / 2) / DIV. The last quotient
  // is taken as (num * RCP) >> RCP_SHIFT, which is exact for num below 2^59.
  localparam int unsigned NUM_W = 59;
  localparam int unsigned RCP_W = 61;
  localparam int unsigned RCP_SHIFT = 92;
  localparam logic [4:0] QP_FULL = 5'(PIQ34 / 36'(DIV_FULL));
  localparam logic [4:0] QP_HALF = 5'(PIQ34 / 36'(DIV_HALF));
  localparam logic [30:0] RP_FULL = 31'(PIQ34 % 36'(DIV_FULL));
  localparam logic [30:0] RP_HALF = 31'(PIQ34 % 36'(DIV_HALF));
  localparam logic [127:0] RCP_FULL_X =
    ((128'd1 << RCP_SHIFT) + 128'(DIV_FULL) - 128'd1) / 128'(DIV_FULL);
  localparam logic [127:0] RCP_HALF_X =
    ((128'd1 << RCP_SHIFT) + 128'(DIV_HALF) - 128'd1) / 128'(DIV_HALF);
  localparam logic [RCP_W-1:0] RCP_FULL = RCP_FULL_X[RCP_W-1:0];
  localparam logic [RCP_W-1:0] RCP_HALF = RCP_HALF_X[RCP_W-1:0];

  localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;
  localparam logic [30:0] TWO_R_CM = 31'd1274200000;
  localparam logic [30:0] HALF_CIRC_CM = 31'd2001508680;

  localparam int unsigned CORDIC_STEPS_DEF = 32;

  // Arctangent of 2^-idx in Q2.30.
  function automatic logic signed [ANG_W-1:0] atan_q30(input int unsigned idx);
    logic signed [ANG_W-1:0] res;
    case (idx)
      0: res = 34'sd843314857;
      1: res = 34'sd497837829;
      2: res = 34'sd263043837;
      3: res = 34'sd133525159;
      4: res = 34'sd67021687;
      5: res = 34'sd33543516;
      6: res = 34'sd16775851;
      7: res = 34'sd8388437;
      8: res = 34'sd4194283;
      9: res = 34'sd2097149;
      default: begin
        if (idx <= 30) res = 34'sd1 <<< (30 - idx);
        else res = '0;
      end
    endcase
    return res;
  endfunction

endpackage

/* rtl/core/hvd_div_cell.sv */
`timescale 1ns / 1ps
module hvd_div_cell
  import hvd_pkg::*;
#(
  parameter bit HALF = 1'b0
) (
  input  logic             clk_i,
  input  logic             ce_i,
  input  logic [27:0]      u_i,
  output logic [QUO_W-1:0] quo_o
);

  localparam logic [REM_W-1:0] Div = HALF ? DIV_HALF : DIV_FULL;
  localparam logic [4:0]       Qp  = HALF ? QP_HALF : QP_FULL;
  localparam logic [30:0]      Rp  = HALF ? RP_HALF : RP_FULL;
  localparam logic [RCP_W-1:0] Rcp = HALF ? RCP_HALF : RCP_FULL;

  logic [NUM_W-1:0] num_q;
  logic [QUO_W-1:0] base_q [4];
  logic [63:0]      hh_q, hl_q, lh_q, ll_q, hh2_q, ll2_q;
  logic [64:0]      mid_q;
  logic [119:0]     sum_d, sum_q;

  // Full product of the partial products, aligned by their weights.
  assign sum_d = (120'(hh2_q) << 64) + (120'(mid_q) << 32) + 120'(ll2_q);

  // Five-stage rounded division by a constant through a reciprocal multiply.
  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      // Whole multiples of the divisor apart, rounding offset added.
      num_q     <= NUM_W'(u_i) * NUM_W'(Rp) + NUM_W'(Div >> 1);
      base_q[0] <= QUO_W'(u_i) * QUO_W'(Qp);
      // Four 32-bit partial products with the reciprocal.
      hh_q      <= 64'(num_q[NUM_W-1:32]) * 64'(Rcp[RCP_W-1:32]);
      hl_q      <= 64'(num_q[NUM_W-1:32]) * 64'(Rcp[31:0]);
      lh_q      <= 64'(num_q[31:0]) * 64'(Rcp[RCP_W-1:32]);
      ll_q      <= 64'(num_q[31:0]) * 64'(Rcp[31:0]);
      base_q[1] <= base_q[0];
      // Middle terms combined.
      mid_q     <= 65'(hl_q) + 65'(lh_q);
      hh2_q     <= hh_q;
      ll2_q     <= ll_q;
      base_q[2] <= base_q[1];
      // Full sum, then the quotient from its top bits.
      sum_q     <= sum_d;
      base_q[3] <= base_q[2];
      quo_o     <= base_q[3] + QUO_W'(sum_q[119:RCP_SHIFT]);
    end
  end

endmodule

/* rtl/core/hvd_cordic_cell.sv */
`timescale 1ns / 1ps
module hvd_cordic_cell
  import hvd_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter bit VECTOR = 1'b0
) (
  input  logic                    clk_i,
  input  logic                    ce_i,
  input  logic signed [ANG_W-1:0] x_i,
  input  logic signed [ANG_W-1:0] y_i,
  input  logic signed [ANG_W-1:0] z_i,
  output logic signed [ANG_W-1:0] x_o,
  output logic signed [ANG_W-1:0] y_o,
  output logic signed [ANG_W-1:0] z_o
);

  localparam logic signed [ANG_W-1:0] Atan = atan_q30(IDX);

  logic signed [ANG_W-1:0] dx, dy, x_d, y_d, z_d;
  logic                    pos;

  // One micro-rotation; direction from the angle or from the sign of y.
  always_comb begin
    dx  = y_i >>> IDX;
    dy  = x_i >>> IDX;
    pos = VECTOR ? ~y_i[ANG_W-1] : ~z_i[ANG_W-1];
    if (VECTOR) begin
      if (pos) begin
        x_d = x_i + dx;
        y_d = y_i - dy;
        z_d = z_i + Atan;
      end else begin
        x_d = x_i - dx;
        y_d = y_i + dy;
        z_d = z_i - Atan;
      end
    end else begin
      if (pos) begin
        x_d = x_i - dx;
        y_d = y_i + dy;
        z_d = z_i - Atan;
      end else begin
        x_d = x_i + dx;
        y_d = y_i - dy;
        z_d = z_i + Atan;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      x_o <= x_d;
      y_o <= y_d;
      z_o <= z_d;
    end
  end

endmodule

/* rtl/core/hvd_sqrt_cell.sv */
`timescale 1ns / 1ps
module hvd_sqrt_cell
  import hvd_pkg::*;
#(
  parameter int unsigned K = 0
) (
  input  logic            clk_i,
  input  logic            ce_i,
  input  logic [SQ_W-1:0] v_i,
  input  logic [SQ_W-1:0] r_i,
  output logic [SQ_W-1:0] v_o,
  output logic [SQ_W-1:0] r_o
);

  localparam logic [SQ_W-1:0] Bit = SQ_W'(1) << (2 * K);

  logic [SQ_W:0]   sum;
  logic [SQ_W-1:0] v_d, r_d;

  // One digit of the integer square root, weight four to the K.
  always_comb begin
    sum = {1'b0, r_i} + {1'b0, Bit};
    if ({1'b0, v_i} >= sum) begin
      v_d = v_i - sum[SQ_W-1:0];
      r_d = (r_i >> 1) + Bit;
    end else begin
      v_d = v_i;
      r_d = r_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      v_o <= v_d;
      r_o <= r_d;
    end
  end

endmodule

/* rtl/core/haversine_distance.sv */
`timescale 1ns / 1ps
// Haversine great-circle distance. Each transfer carries two points in signed
// microdegrees; the block returns their distance in centimetres over a sphere
// of radius 6371 km, rounded and saturated at half the circumference. The
// datapath is a fully pipelined chain of cells: four five-stage reciprocal
// multiply converters turn the angles into Q2.30 radians, four rotation CORDIC
// rows give the sines and cosines, two rows of square-root cells and one
// vectoring CORDIC row give the central angle. A new point pair is taken every
// cycle while the output is not stalled. The latency is set mostly by the
// 31-cell root rows and the two CORDIC rows that lie in series. The whole
// pipeline holds while a finished result waits on the output.
module haversine_distance
  import hvd_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // first_lat_udeg [27:0], first_lon_udeg [56:28], second_lat_udeg [84:57],
  // second_lon_udeg [113:85], zero fill [119:114]
  input  logic [119:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // distance_cm [30:0], zero fill [31]
  output logic [31:0]  m_axis_tdata
);

  localparam int unsigned Lat = 42 + 2 * CORDIC_STEPS;

  logic           ce;
  logic [Lat-1:0] vld_q;

  // Pipeline advances whenever the output register is free or being taken.
  assign ce            = ~vld_q[Lat-1] | m_axis_tready;
  assign s_axis_tready = ce;
  assign m_axis_tvalid = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end

  // Clamp, difference, wrap and magnitude of the angles.
  logic signed [27:0] lat1, lat2, lat1_c, lat2_c;
  logic signed [28:0] lon1, lon2, lon1_c, lon2_c, dlat;
  logic signed [29:0] dlon;
  logic        [27:0] u_d [4];
  logic        [27:0] u_q [4];

  assign lat1 = s_axis_tdata[27:0];
  assign lon1 = s_axis_tdata[56:28];
  assign lat2 = s_axis_tdata[84:57];
  assign lon2 = s_axis_tdata[113:85];

  always_comb begin
    lat1_c = (lat1 > LAT_MAX) ? LAT_MAX : ((lat1 < -LAT_MAX) ? -LAT_MAX : lat1);
    lat2_c = (lat2 > LAT_MAX) ? LAT_MAX : ((lat2 < -LAT_MAX) ? -LAT_MAX : lat2);
    lon1_c = (lon1 > LON_MAX) ? LON_MAX : ((lon1 < -LON_MAX) ? -LON_MAX : lon1);
    lon2_c = (lon2 > LON_MAX) ? LON_MAX : ((lon2 < -LON_MAX) ? -LON_MAX : lon2);
    dlat = 29'(lat2_c) - 29'(lat1_c);
    dlon = 30'(lon2_c) - 30'(lon1_c);
    if (dlon > 30'(LON_MAX)) dlon = dlon - TURN_UDEG;
    if (dlon < -30'(LON_MAX)) dlon = dlon + TURN_UDEG;
    u_d[0] = dlat[28] ? 28'(-dlat) : 28'(dlat);
    u_d[1] = dlon[29] ? 28'(-dlon) : 28'(dlon);
    u_d[2] = lat1_c[27] ? 28'(-lat1_c) : 28'(lat1_c);
    u_d[3] = lat2_c[27] ? 28'(-lat2_c) : 28'(lat2_c);
  end

  always_ff @(posedge clk_i) begin
    if (ce) u_q <= u_d;
  end

  // Angle conversion and sine/cosine rows; channels are dLat/2, dLon/2,
  // lat1 and lat2.
  logic        [QUO_W-1:0] ang_q [4];
  logic signed [ANG_W-1:0] rx [4][CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] ry [4][CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] rz [4][CORDIC_STEPS+1];

  for (genvar ch = 0; ch < 4; ch++) begin : g_ang
    hvd_div_cell #(
      .HALF (ch < 2)
    ) u_div (
      .clk_i (clk_i),
      .ce_i  (ce),
      .u_i   (u_q[ch]),
      .quo_o (ang_q[ch])
    );

    assign rx[ch][0] = CORDIC_GAIN;
    assign ry[ch][0] = '0;
    assign rz[ch][0] = ANG_W'(ang_q[ch]);

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      hvd_cordic_cell #(
        .IDX    (i),
        .VECTOR (1'b0)
      ) u_rot (
        .clk_i (clk_i),
        .ce_i  (ce),
        .x_i   (rx[ch][i]),
        .y_i   (ry[ch][i]),
        .z_i   (rz[ch][i]),
        .x_o   (rx[ch][i+1]),
        .y_o   (ry[ch][i+1]),
        .z_o   (rz[ch][i+1])
      );
    end
  end

  // Haversine term a, clamped to [0, 1], and its complement.
  logic signed [31:0] s1, s2, c1, c2;
  logic signed [63:0] s1sq_p, s2sq_p, cc_p, t_p;
  logic signed [31:0] s1sq_q, s2sq_q, cc_q, s1sq2_q, t_q;
  logic signed [32:0] a_sum;
  logic        [30:0] a_q, b_q;

  assign s1     = 32'(ry[0][CORDIC_STEPS]);
  assign s2     = 32'(ry[1][CORDIC_STEPS]);
  assign c1     = 32'(rx[2][CORDIC_STEPS]);
  assign c2     = 32'(rx[3][CORDIC_STEPS]);
  assign s1sq_p = s1 * s1;
  assign s2sq_p = s2 * s2;
  assign cc_p   = c1 * c2;
  assign t_p    = cc_q * s2sq_q;
  assign a_sum  = 33'(s1sq2_q) + 33'(t_q);

  always_ff @(posedge clk_i) begin
    if (ce) begin
      s1sq_q  <= 32'(s1sq_p >>> 30);
      s2sq_q  <= 32'(s2sq_p >>> 30);
      cc_q    <= 32'(cc_p >>> 30);
      s1sq2_q <= s1sq_q;
      t_q     <= 32'(t_p >>> 30);
      if (a_sum < 0) begin
        a_q <= '0;
        b_q <= ONE_Q30;
      end else if (a_sum > 33'(ONE_Q30)) begin
        a_q <= ONE_Q30;
        b_q <= '0;
      end else begin
        a_q <= 31'(a_sum);
        b_q <= ONE_Q30 - 31'(a_sum);
      end
    end
  end

  // Square roots of a and 1 - a.
  logic [SQ_W-1:0] sa_v [QUO_W+1];
  logic [SQ_W-1:0] sa_r [QUO_W+1];
  logic [SQ_W-1:0] sb_v [QUO_W+1];
  logic [SQ_W-1:0] sb_r [QUO_W+1];

  assign sa_v[0] = {a_q, 30'd0};
  assign sa_r[0] = '0;
  assign sb_v[0] = {b_q, 30'd0};
  assign sb_r[0] = '0;

  for (genvar k = 0; k < QUO_W; k++) begin : g_sqrt
    hvd_sqrt_cell #(.K(QUO_W - 1 - k)) u_sqa (
      .clk_i (clk_i),
      .ce_i  (ce),
      .v_i   (sa_v[k]),
      .r_i   (sa_r[k]),
      .v_o   (sa_v[k+1]),
      .r_o   (sa_r[k+1])
    );
    hvd_sqrt_cell #(.K(QUO_W - 1 - k)) u_sqb (
      .clk_i (clk_i),
      .ce_i  (ce),
      .v_i   (sb_v[k]),
      .r_i   (sb_r[k]),
      .v_o   (sb_v[k+1]),
      .r_o   (sb_r[k+1])
    );
  end

  // Half central angle by vectoring CORDIC.
  logic signed [ANG_W-1:0] vx [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] vy [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] vz [CORDIC_STEPS+1];

  assign vx[0] = ANG_W'(sb_r[QUO_W]);
  assign vy[0] = ANG_W'(sa_r[QUO_W]);
  assign vz[0] = '0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    hvd_cordic_cell #(
      .IDX    (i),
      .VECTOR (1'b1)
    ) u_vec (
      .clk_i (clk_i),
      .ce_i  (ce),
      .x_i   (vx[i]),
      .y_i   (vy[i]),
      .z_i   (vz[i]),
      .x_o   (vx[i+1]),
      .y_o   (vy[i+1]),
      .z_o   (vz[i+1])
    );
  end

  // Scale by the Earth's diameter, round and saturate.
  logic        [30:0] zc;
  logic        [61:0] prod_q;
  logic        [62:0] dist_r;
  logic        [32:0] dist_rnd;
  logic        [30:0] dist_q;

  assign zc       = vz[CORDIC_STEPS][ANG_W-1] ? '0 : 31'(vz[CORDIC_STEPS]);
  assign dist_r   = 63'(prod_q) + (63'd1 << 29);
  assign dist_rnd = 33'(dist_r >> 30);

  always_ff @(posedge clk_i) begin
    if (ce) begin
      prod_q <= 62'(zc) * 62'(TWO_R_CM);
      dist_q <= (dist_rnd > 33'(HALF_CIRC_CM)) ? HALF_CIRC_CM : 31'(dist_rnd);
    end
  end

  assign m_axis_tdata = {1'b0, dist_q};

`ifndef ASSERT_OFF
  // A valid result never exceeds half the circumference.
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[30:0] <= HALF_CIRC_CM) && !m_axis_tdata[31])
    else $error("distance beyond half circumference");

  // A stalled pipeline keeps the valid flags of all of its items in place.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ce |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

  // An item enters the first stage exactly when it is transferred in.
  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ce |=> vld_q[0] == $past(s_axis_tvalid))
    else $error("input transfer lost or invented");
`endif

endmodule
